/* rtl/srf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srf_pkg;

  localparam int COORD_W = 16;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_FILL = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [7:0] CMD_CASET = 8'h2A;
  localparam logic [7:0] CMD_PASET = 8'h2B;
  localparam logic [7:0] CMD_RAMWR = 8'h2C;
  localparam logic [7:0] CMD_RDIDX = 8'hD9;
  localparam logic [7:0] RDIDX_ARG = 8'h10;

  typedef struct packed {
    logic [1:0]         action;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [15:0]        pixel_color;
    logic [7:0]         command_code;
    logic               miso;
  } req_t;

  typedef struct packed {
    logic       cs_active;
    logic       dc_data;
    logic       mosi;
    logic       clock_pulse;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/srf_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface srf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/spi_display_rect_fill_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial display master. Each request item is either a tick (one serial clock
// period, one bit out or in) or a start of a rectangle fill or a register read; a
// start while a sequence runs is dropped. Every item yields exactly one result. The
// block takes one item per cycle while the result side is not stalled: an input
// register feeds a single pass of sequencer logic that updates the state and loads
// the result register when that register is free or being taken, so each result
// passes through the input register and then the result register; a result that is
// not taken holds the sequencer and the input. A fill needs 88 ticks of header plus 16
// ticks per pixel (width * height pixels); a read needs 32 ticks.
module spi_display_rect_fill_sequencer #(
  parameter int COORD_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  srf_stream_if.sink   req,
  srf_stream_if.source rsp
);
  import srf_pkg::*;

  localparam int PIX_BITS = 2 * COORD_BITS;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_FILL_HDR = 3'd1;
  localparam logic [2:0] PH_FILL_PIX = 3'd2;
  localparam logic [2:0] PH_RD_HDR   = 3'd3;
  localparam logic [2:0] PH_RD_IN    = 3'd4;

  // input register
  logic s1_valid;
  req_t s1;
  logic advance;

  // sequencer state
  logic [2:0]            phase, phase_next;
  logic [3:0]            byte_step, byte_step_next;
  logic [2:0]            bit_step, bit_step_next;
  logic [PIX_BITS-1:0]   pixels_left, pixels_left_next;
  logic [COORD_BITS-1:0] saved_x, saved_x_next;
  logic [COORD_BITS-1:0] saved_x_end, saved_x_end_next;
  logic [COORD_BITS-1:0] saved_y, saved_y_next;
  logic [COORD_BITS-1:0] saved_y_end, saved_y_end_next;
  logic [15:0]           saved_color, saved_color_next;
  logic [7:0]            saved_command, saved_command_next;
  logic [7:0]            in_shift, in_shift_next;

  // output register
  logic out_valid;
  rsp_t out_data;
  rsp_t res;

  logic [COORD_BITS-1:0] cx, cy, cw, ch;
  logic                  is_fill, is_read, is_req;
  logic [7:0]            cur_byte;
  logic                  cur_dc;
  logic [COORD_W-1:0]    x16, xe16, y16, ye16;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
  end

  assign cx = s1.x_start[COORD_BITS-1:0];
  assign cy = s1.y_start[COORD_BITS-1:0];
  assign cw = s1.width[COORD_BITS-1:0];
  assign ch = s1.height[COORD_BITS-1:0];

  assign is_fill = (s1.action == ACT_FILL);
  assign is_read = (s1.action == ACT_READ);
  assign is_req  = is_fill || is_read;

  assign x16  = COORD_W'(saved_x);
  assign xe16 = COORD_W'(saved_x_end);
  assign y16  = COORD_W'(saved_y);
  assign ye16 = COORD_W'(saved_y_end);

  // byte at the current position and its data/command level
  always_comb begin
    cur_byte = 8'h00;
    cur_dc   = 1'b1;
    unique case (phase)
      PH_FILL_HDR: begin
        case (byte_step)
          4'd0: begin
            cur_byte = CMD_CASET;
            cur_dc   = 1'b0;
          end
          4'd1: cur_byte = x16[15:8];
          4'd2: cur_byte = x16[7:0];
          4'd3: cur_byte = xe16[15:8];
          4'd4: cur_byte = xe16[7:0];
          4'd5: begin
            cur_byte = CMD_PASET;
            cur_dc   = 1'b0;
          end
          4'd6: cur_byte = y16[15:8];
          4'd7: cur_byte = y16[7:0];
          4'd8: cur_byte = ye16[15:8];
          4'd9: cur_byte = ye16[7:0];
          default: begin
            cur_byte = CMD_RAMWR;
            cur_dc   = 1'b0;
          end
        endcase
      end
      PH_FILL_PIX: begin
        cur_byte = (byte_step == 4'd0) ? saved_color[15:8] : saved_color[7:0];
      end
      PH_RD_HDR: begin
        if (byte_step == 4'd0) begin
          cur_byte = CMD_RDIDX;
          cur_dc   = 1'b0;
        end else if (byte_step == 4'd1) begin
          cur_byte = RDIDX_ARG;
        end else begin
          cur_byte = saved_command;
          cur_dc   = 1'b0;
        end
      end
      PH_IDLE: cur_dc = 1'b0;
      default: cur_dc = 1'b1;
    endcase
  end

  always_comb begin
    phase_next         = phase;
    byte_step_next     = byte_step;
    bit_step_next      = bit_step;
    pixels_left_next   = pixels_left;
    saved_x_next       = saved_x;
    saved_x_end_next   = saved_x_end;
    saved_y_next       = saved_y;
    saved_y_end_next   = saved_y_end;
    saved_color_next   = saved_color;
    saved_command_next = saved_command;
    in_shift_next      = in_shift;
    res                = '0;

    if (phase == PH_IDLE && is_req) begin
      byte_step_next = 4'd0;
      bit_step_next  = 3'd0;
      in_shift_next  = 8'h00;
      if (is_fill) begin
        saved_x_next     = cx;
        saved_y_next     = cy;
        saved_x_end_next = cx + cw - COORD_BITS'(1);
        saved_y_end_next = cy + ch - COORD_BITS'(1);
        saved_color_next = s1.pixel_color;
        pixels_left_next = {{COORD_BITS{1'b0}}, cw} * {{COORD_BITS{1'b0}}, ch};
        phase_next       = PH_FILL_HDR;
      end else begin
        saved_command_next = s1.command_code;
        phase_next         = PH_RD_HDR;
      end
      // both sequences open with a command byte
      res.cs_active = 1'b1;
      res.dc_data   = 1'b0;
    end else if (phase != PH_IDLE && !is_req) begin
      res.cs_active   = 1'b1;
      res.clock_pulse = 1'b1;
      if (phase == PH_RD_IN) begin
        res.dc_data   = 1'b1;
        in_shift_next = {in_shift[6:0], s1.miso};
        if (bit_step == 3'd7) begin
          bit_step_next  = 3'd0;
          res.read_data  = in_shift_next;
          res.read_valid = 1'b1;
          phase_next     = PH_IDLE;
        end else begin
          bit_step_next = bit_step + 3'd1;
        end
      end else begin
        res.dc_data = cur_dc;
        res.mosi    = cur_byte[~bit_step];
        if (bit_step == 3'd7) begin
          bit_step_next = 3'd0;
          case (phase)
            PH_FILL_HDR: begin
              if (byte_step >= 4'd10) begin
                byte_step_next = 4'd0;
                phase_next     = (pixels_left == '0) ? PH_IDLE : PH_FILL_PIX;
              end else begin
                byte_step_next = byte_step + 4'd1;
              end
            end
            PH_FILL_PIX: begin
              if (byte_step == 4'd0) begin
                byte_step_next = 4'd1;
              end else begin
                byte_step_next   = 4'd0;
                pixels_left_next = pixels_left - PIX_BITS'(1);
                if (pixels_left_next == '0) begin
                  phase_next = PH_IDLE;
                end
              end
            end
            PH_RD_HDR: begin
              if (byte_step >= 4'd2) begin
                byte_step_next = 4'd0;
                phase_next     = PH_RD_IN;
                in_shift_next  = 8'h00;
              end else begin
                byte_step_next = byte_step + 4'd1;
              end
            end
            default: begin
              byte_step_next = byte_step;
            end
          endcase
        end else begin
          bit_step_next = bit_step + 3'd1;
        end
      end
    end else if (phase != PH_IDLE) begin
      // start request while busy: dropped, lines hold
      res.cs_active = 1'b1;
      res.dc_data   = (phase == PH_RD_IN) ? 1'b1 : cur_dc;
    end

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      byte_step   <= 4'd0;
      bit_step    <= 3'd0;
      pixels_left <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      byte_step   <= byte_step_next;
      bit_step    <= bit_step_next;
      pixels_left <= pixels_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      saved_x       <= saved_x_next;
      saved_x_end   <= saved_x_end_next;
      saved_y       <= saved_y_next;
      saved_y_end   <= saved_y_end_next;
      saved_color   <= saved_color_next;
      saved_command <= saved_command_next;
      in_shift      <= in_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

/* rtl/srf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module srf_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         rsp_valid,
  input wire logic         rsp_ready,
  input wire srf_pkg::rsp_t rsp_data
);
  import srf_pkg::*;

  // no result may be offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // the last read bit ends the sequence
  a_read_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.read_valid |-> !rsp_data.busy_res && rsp_data.clock_pulse)
    else $error("read completion without pulse or with busy still set");

  // serial activity only under chip select
  a_pulse_cs: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.clock_pulse || rsp_data.mosi || rsp_data.busy_res)
      |-> rsp_data.cs_active)
    else $error("serial activity without chip select");

  // data bit only with a clock pulse
  a_mosi_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.mosi |-> rsp_data.clock_pulse)
    else $error("mosi high without clock pulse");

  // a read byte is reported only in a single result
  a_read_once: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && rsp_data.read_valid |=> !(rsp_valid && rsp_data.read_valid))
    else $error("read completion reported twice in a row");

endmodule

bind spi_display_rect_fill_sequencer srf_checker u_srf_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

/* sim/srf_pin_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the serial pin states for every accepted
// request and compares them in order with the results.
module srf_pin_checker
  import srf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  srf_stream_if req_mon,
  srf_stream_if rsp_mon,
  output int    fail_count,
  output int    pending
);

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_FILL_HDR,
    SEQ_FILL_PIX,
    SEQ_RD_HDR,
    SEQ_RD_IN
  } seq_e;

  seq_e               seq = SEQ_IDLE;
  logic [3:0]         byte_idx = '0;
  logic [2:0]         bit_idx = '0;
  logic [7:0]         tx_shift = '0;
  logic [31:0]        pix_left = '0;
  logic [COORD_W-1:0] col = '0;
  logic [COORD_W-1:0] col_end = '0;
  logic [COORD_W-1:0] row = '0;
  logic [COORD_W-1:0] row_end = '0;
  logic [15:0]        color = '0;
  logic [7:0]         cmd = '0;
  logic [7:0]         rx_shift = '0;

  rsp_t pin_states_due[$];
  int   errs = 0;

  // Byte at the current position of the sequence and its DC level.
  function automatic logic [7:0] tx_byte(output logic dc);
    dc = 1'b1;
    tx_byte = 8'h00;
    case (seq)
      SEQ_FILL_HDR: begin
        case (byte_idx)
          4'd0: begin dc = 1'b0; tx_byte = CMD_CASET; end
          4'd1: tx_byte = 8'(col >> 8);
          4'd2: tx_byte = col[7:0];
          4'd3: tx_byte = 8'(col_end >> 8);
          4'd4: tx_byte = col_end[7:0];
          4'd5: begin dc = 1'b0; tx_byte = CMD_PASET; end
          4'd6: tx_byte = 8'(row >> 8);
          4'd7: tx_byte = row[7:0];
          4'd8: tx_byte = 8'(row_end >> 8);
          4'd9: tx_byte = row_end[7:0];
          default: begin dc = 1'b0; tx_byte = CMD_RAMWR; end
        endcase
      end
      SEQ_FILL_PIX: tx_byte = (byte_idx == 4'd0) ? color[15:8] : color[7:0];
      SEQ_RD_HDR: begin
        if (byte_idx == 4'd0) begin
          dc = 1'b0;
          tx_byte = CMD_RDIDX;
        end else if (byte_idx == 4'd1) begin
          tx_byte = RDIDX_ARG;
        end else begin
          dc = 1'b0;
          tx_byte = cmd;
        end
      end
      SEQ_IDLE: dc = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic void next_byte();
    case (seq)
      SEQ_FILL_HDR: begin
        if (byte_idx >= 4'd10) begin
          byte_idx = '0;
          seq = (pix_left == 0) ? SEQ_IDLE : SEQ_FILL_PIX;
        end else begin
          byte_idx++;
        end
      end
      SEQ_FILL_PIX: begin
        if (byte_idx == 4'd0) begin
          byte_idx = 4'd1;
        end else begin
          byte_idx = '0;
          pix_left--;
          if (pix_left == 0) seq = SEQ_IDLE;
        end
      end
      SEQ_RD_HDR: begin
        if (byte_idx >= 4'd2) begin
          byte_idx = '0;
          seq = SEQ_RD_IN;
          rx_shift = '0;
        end else begin
          byte_idx++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic rsp_t next_pin_state(req_t item);
    rsp_t       o;
    logic       dc_lvl;
    logic [7:0] b;
    logic       is_start;
    o = '0;
    is_start = (item.action == ACT_FILL) || (item.action == ACT_READ);
    if (seq == SEQ_IDLE && is_start) begin
      byte_idx = '0;
      bit_idx = '0;
      rx_shift = '0;
      if (item.action == ACT_FILL) begin
        col = item.x_start;
        row = item.y_start;
        col_end = item.x_start + item.width - 1'b1;
        row_end = item.y_start + item.height - 1'b1;
        color = item.pixel_color;
        pix_left = 32'(item.width) * 32'(item.height);
        seq = SEQ_FILL_HDR;
      end else begin
        cmd = item.command_code;
        seq = SEQ_RD_HDR;
      end
      o.cs_active = 1'b1;
      b = tx_byte(dc_lvl);
      o.dc_data = dc_lvl;
    end else if (seq != SEQ_IDLE && !is_start) begin
      o.cs_active = 1'b1;
      o.clock_pulse = 1'b1;
      if (seq == SEQ_RD_IN) begin
        o.dc_data = 1'b1;
        rx_shift = {rx_shift[6:0], item.miso};
        if (bit_idx == 3'd7) begin
          bit_idx = '0;
          o.read_data = rx_shift;
          o.read_valid = 1'b1;
          seq = SEQ_IDLE;
        end else begin
          bit_idx++;
        end
      end else begin
        b = tx_byte(dc_lvl);
        o.dc_data = dc_lvl;
        if (bit_idx == 3'd0) tx_shift = b;
        o.mosi = tx_shift[7];
        tx_shift = tx_shift << 1;
        if (bit_idx == 3'd7) begin
          bit_idx = '0;
          next_byte();
        end else begin
          bit_idx++;
        end
      end
    end else if (seq != SEQ_IDLE) begin
      // start while busy: dropped, pins hold
      o.cs_active = 1'b1;
      if (seq == SEQ_RD_IN) begin
        o.dc_data = 1'b1;
      end else begin
        b = tx_byte(dc_lvl);
        o.dc_data = dc_lvl;
      end
    end
    o.busy_res = (seq != SEQ_IDLE);
    return o;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst) begin
      seq = SEQ_IDLE;
      byte_idx = '0;
      bit_idx = '0;
      tx_shift = '0;
      pix_left = '0;
      col = '0;
      col_end = '0;
      row = '0;
      row_end = '0;
      color = '0;
      cmd = '0;
      rx_shift = '0;
      pin_states_due.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        pin_states_due.push_back(next_pin_state(req_mon.data));
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = rsp_mon.data;
        if (pin_states_due.size() == 0) begin
          $error("result transfer with no request outstanding");
          errs++;
        end else begin
          want = pin_states_due.pop_front();
          check_field("cs_active", 8'(want.cs_active), 8'(got.cs_active));
          check_field("dc_data", 8'(want.dc_data), 8'(got.dc_data));
          check_field("mosi", 8'(want.mosi), 8'(got.mosi));
          check_field("clock_pulse", 8'(want.clock_pulse), 8'(got.clock_pulse));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
          check_field("read_data", want.read_data, got.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
        end
      end
      fail_count <= errs;
      pending <= pin_states_due.size();
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import srf_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;  // unused code, behaves as a tick
  localparam int HDR_TICKS = 88;
  localparam int PIX_TICKS = 16;
  localparam int RD_TICKS = 32;
  localparam int WORK_TARGET = 450;

  localparam int MISO_ZERO = 0;
  localparam int MISO_ONE = 1;
  localparam int MISO_RAND = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   work_done = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;

  srf_stream_if #(.payload_t(req_t)) req_ch ();
  srf_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  spi_display_rect_fill_sequencer #(.COORD_BITS(COORD_W)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  srf_pin_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_mon    (req_ch),
    .rsp_mon    (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  function automatic int draw_gap(bit burst);
    if (burst || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic req_t rand_req(logic [1:0] act);
    req_t r;
    r.action = act;
    r.x_start = 16'($urandom);
    r.y_start = 16'($urandom);
    r.width = 16'($urandom);
    r.height = 16'($urandom);
    r.pixel_color = 16'($urandom);
    r.command_code = 8'($urandom);
    r.miso = 1'($urandom);
    return r;
  endfunction

  task automatic send_req(input req_t item);
    int gap;
    gap = draw_gap(tx_burst);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
  endtask

  // hold off the sender until every result has come back
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic run_ticks(input int n, input int miso_mode, input bit noisy);
    req_t r;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) begin
        send_req(rand_req($urandom_range(0, 1) ? ACT_FILL : ACT_READ));
      end
      r = rand_req(($urandom_range(0, 7) == 0) ? ACT_SPARE : ACT_TICK);
      if (miso_mode == MISO_ZERO) r.miso = 1'b0;
      else if (miso_mode == MISO_ONE) r.miso = 1'b1;
      send_req(r);
      work_done++;
    end
  endtask

  task automatic start_fill(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
                            input logic [15:0] h, input logic [15:0] c, output int ticks);
    req_t r;
    r = rand_req(ACT_FILL);
    r.x_start = x;
    r.y_start = y;
    r.width = w;
    r.height = h;
    r.pixel_color = c;
    send_req(r);
    work_done++;
    ticks = HDR_TICKS + PIX_TICKS * int'(w) * int'(h);
  endtask

  task automatic start_read(input logic [7:0] code);
    req_t r;
    r = rand_req(ACT_READ);
    r.command_code = code;
    send_req(r);
    work_done++;
  endtask

  // receiver: random stalls, one long hold while the sender keeps pushing
  initial begin
    int gap;
    int rx_count;
    rx_count = 0;
    rsp_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rx_burst);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (rx_count == 150) gap = 120;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      rx_count++;
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int   ticks;
    bit   paused;
    req_t r;
    logic [15:0] w;
    logic [15:0] h;
    paused = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // ticks with nothing running
    send_req(rand_req(ACT_TICK));
    send_req(rand_req(ACT_SPARE));

    // single pixel, starts dropped mid-sequence
    start_fill(16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'hFFFF, ticks);
    run_ticks(40, MISO_RAND, 1'b0);
    send_req(rand_req(ACT_READ));
    send_req(rand_req(ACT_FILL));
    run_ticks(ticks - 40, MISO_RAND, 1'b0);

    // empty rectangles at the coordinate extremes
    start_fill(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, ticks);
    run_ticks(ticks, MISO_RAND, 1'b0);
    start_fill(16'hFFFE, 16'h8001, 16'h0000, 16'hFFFF, 16'hA5A5, ticks);
    run_ticks(ticks, MISO_RAND, 1'b0);

    // end column wraps past the top of the range
    start_fill(16'hFFFF, 16'hFFFF, 16'h0002, 16'h0001, 16'h00FF, ticks);
    run_ticks(ticks, MISO_RAND, 1'b0);

    start_read(8'h00);
    run_ticks(RD_TICKS, MISO_ONE, 1'b0);
    start_read(8'hFF);
    run_ticks(RD_TICKS, MISO_ZERO, 1'b0);
    start_read(8'($urandom));
    send_req(rand_req(ACT_FILL));
    run_ticks(RD_TICKS, MISO_RAND, 1'b0);

    drain();

    while (work_done < WORK_TARGET) begin
      if (!paused && work_done >= WORK_TARGET / 2) begin
        drain();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          start_read(8'($urandom));
          ticks = RD_TICKS;
        end
        4, 5, 6, 7, 8: begin
          case ($urandom_range(0, 9))
            0: begin w = 16'($urandom); h = '0; end
            1: begin w = '0; h = 16'($urandom); end
            default: begin
              w = 16'($urandom_range(0, 2));
              h = 16'($urandom_range(0, 2));
            end
          endcase
          start_fill(16'($urandom), 16'($urandom), w, h, 16'($urandom), ticks);
        end
        default: begin
          // stray items between sequences
          repeat ($urandom_range(1, 3)) begin
            r = rand_req(2'($urandom_range(0, 3)));
            if (r.action == ACT_FILL) r.width = 16'($urandom_range(0, 1));
            send_req(r);
          end
          ticks = 0;
        end
      endcase
      // broken sequence: stop short, the leftover eats later items
      if (ticks > 1 && $urandom_range(0, 7) == 0) ticks = $urandom_range(1, ticks - 1);
      run_ticks(ticks, MISO_RAND, 1'b1);
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
